@@ hdl/srb_pkg.sv @@
// Package for the sequence reorder buffer: sizes, register map and shared types.
// No dependencies.
package srb_pkg;

    localparam int SLOTS = 16;
    localparam int NUM_STREAMS = 2;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int ADDR_W = $clog2(SLOTS * NUM_STREAMS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int SEQ_W = 32;
    localparam int TAG_W = 32;
    localparam int LIMIT_W = 5;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd8;

    localparam logic [1:0] REG_MAX_HELD = 2'd0;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [TAG_W-1:0] tag;
    } slot_entry_t;

endpackage

@@ hdl/srb_slot_ram.sv @@
// Slot memory holding sequence number and tag of held frames.
// Depends on srb_pkg.
module srb_slot_ram (
    input  logic                       clk,
    input  logic                       we,
    input  logic [srb_pkg::ADDR_W-1:0] waddr,
    input  srb_pkg::slot_entry_t       wdata,
    input  logic [srb_pkg::ADDR_W-1:0] raddr,
    output srb_pkg::slot_entry_t       rdata
);

    srb_pkg::slot_entry_t mem [srb_pkg::SLOTS*srb_pkg::NUM_STREAMS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/srb_cfg.sv @@
// APB register block for the held-frame limit.
// Depends on srb_pkg.
module srb_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [1:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output logic [srb_pkg::CNT_W-1:0]   limit
);

    logic [srb_pkg::LIMIT_W-1:0] max_held_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_held_reg <= srb_pkg::LIMIT_RESET;
        end
        else if (psel && penable && pwrite && paddr == {srb_pkg::REG_MAX_HELD})
        begin
            max_held_reg <= pwdata[srb_pkg::LIMIT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == srb_pkg::REG_MAX_HELD)
                  ? {{(32-srb_pkg::LIMIT_W){1'b0}}, max_held_reg} : 32'd0;

    always_comb
    begin
        priority if (max_held_reg == '0)
            limit = srb_pkg::CNT_W'(1);
        else if (32'(max_held_reg) > srb_pkg::SLOTS)
            limit = srb_pkg::CNT_W'(srb_pkg::SLOTS);
        else
            limit = srb_pkg::CNT_W'(max_held_reg);
    end

endmodule

@@ hdl/sequence_reorder_buffer_top.sv @@
// Sequence reorder buffer for two frame streams; uses srb_pkg, srb_cfg, srb_slot_ram.
// A new frame is taken only in IDLE, once the check and release passes of the last frame finish.
// A frame is dropped after its check pass or stored; each release, skip or discard adds
// a further release pass; a full output register stalls the release pass.
// Each check or release pass reads the 16 slots of the stream from slot memory, one a cycle.
// Reset (rst_n, async) clears held flags, expected sequences and output valid; limit is 8.
module sequence_reorder_buffer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        stream_id,
    input  logic [31:0] seq_num,
    input  logic [31:0] frame_tag,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        out_stream,
    output logic [31:0] out_seq,
    output logic [31:0] out_tag,
    output logic        after_gap,
    output logic        last_of_run
);

    typedef enum logic [2:0] {IDLE, CHECK, INSERT, SCAN, DECIDE} state_t;

    state_t state_reg, state_next;
    logic [srb_pkg::SLOT_W:0] idx_reg, idx_next;
    logic rd_valid_reg, rd_valid_next;
    logic [srb_pkg::SLOT_W-1:0] rd_slot_reg, rd_slot_next;
    logic stream_reg, stream_next;
    logic [srb_pkg::SEQ_W-1:0] seq_reg, seq_next;
    logic [srb_pkg::TAG_W-1:0] tag_reg, tag_next;
    logic [srb_pkg::NUM_STREAMS-1:0][srb_pkg::SEQ_W-1:0] exp_seq_reg, exp_seq_next;
    logic [srb_pkg::NUM_STREAMS-1:0] exp_known_reg, exp_known_next;
    logic [srb_pkg::NUM_STREAMS*srb_pkg::SLOTS-1:0] used_reg, used_next;
    logic match_reg, match_next;
    logic [srb_pkg::SLOT_W-1:0] match_slot_reg, match_slot_next;
    logic [srb_pkg::TAG_W-1:0] match_tag_reg, match_tag_next;
    logic min_ok_reg, min_ok_next;
    logic [srb_pkg::SEQ_W-1:0] min_seq_reg, min_seq_next;
    logic [srb_pkg::SLOT_W-1:0] min_slot_reg, min_slot_next;
    logic gap_reg, gap_next;
    logic pend_reg, pend_next;
    logic [srb_pkg::SEQ_W-1:0] pend_seq_reg, pend_seq_next;
    logic [srb_pkg::TAG_W-1:0] pend_tag_reg, pend_tag_next;
    logic pend_gap_reg, pend_gap_next;
    logic out_valid_reg, out_valid_next;
    logic out_stream_reg, out_stream_next;
    logic [srb_pkg::SEQ_W-1:0] out_seq_reg, out_seq_next;
    logic [srb_pkg::TAG_W-1:0] out_tag_reg, out_tag_next;
    logic out_gap_reg, out_gap_next;
    logic out_last_reg, out_last_next;

    logic [srb_pkg::CNT_W-1:0] limit;
    logic [srb_pkg::SLOTS-1:0] used_s;
    logic [srb_pkg::CNT_W-1:0] held;
    logic [srb_pkg::SLOT_W-1:0] free_idx;
    logic [srb_pkg::SEQ_W-1:0] exp_cur;
    logic [srb_pkg::SEQ_W-1:0] scan_key;
    logic store_ok;
    logic out_free;

    logic ram_we;
    logic [srb_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
    srb_pkg::slot_entry_t ram_wdata, ram_rdata;

    srb_cfg u_cfg (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .limit(limit)
    );

    srb_slot_ram u_ram (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    always_comb
    begin
        used_s = stream_reg ? used_reg[2*srb_pkg::SLOTS-1:srb_pkg::SLOTS]
                            : used_reg[srb_pkg::SLOTS-1:0];
        held = '0;
        free_idx = '0;
        for (int i = srb_pkg::SLOTS - 1; i >= 0; i--)
        begin
            held = held + srb_pkg::CNT_W'(used_s[i]);
            if (!used_s[i])
                free_idx = srb_pkg::SLOT_W'(i);
        end
    end

    assign exp_cur = exp_seq_reg[stream_reg];
    assign scan_key = (state_reg == CHECK) ? seq_reg : exp_cur;
    assign store_ok = !match_reg && (seq_reg >= exp_cur);
    assign out_free = !out_valid_reg || out_ready;

    assign in_ready = (state_reg == IDLE);
    assign out_valid = out_valid_reg;
    assign out_stream = out_stream_reg;
    assign out_seq = out_seq_reg;
    assign out_tag = out_tag_reg;
    assign after_gap = out_gap_reg;
    assign last_of_run = out_last_reg;

    assign ram_raddr = {stream_reg, idx_reg[srb_pkg::SLOT_W-1:0]};
    assign ram_we = (state_reg == INSERT) && store_ok;
    assign ram_waddr = {stream_reg, free_idx};
    assign ram_wdata = '{seq: seq_reg, tag: tag_reg};

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        rd_valid_next = 1'b0;
        rd_slot_next = rd_slot_reg;
        stream_next = stream_reg;
        seq_next = seq_reg;
        tag_next = tag_reg;
        exp_seq_next = exp_seq_reg;
        exp_known_next = exp_known_reg;
        used_next = used_reg;
        match_next = match_reg;
        match_slot_next = match_slot_reg;
        match_tag_next = match_tag_reg;
        min_ok_next = min_ok_reg;
        min_seq_next = min_seq_reg;
        min_slot_next = min_slot_reg;
        gap_next = gap_reg;
        pend_next = pend_reg;
        pend_seq_next = pend_seq_reg;
        pend_tag_next = pend_tag_reg;
        pend_gap_next = pend_gap_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_stream_next = out_stream_reg;
        out_seq_next = out_seq_reg;
        out_tag_next = out_tag_reg;
        out_gap_next = out_gap_reg;
        out_last_next = out_last_reg;
        unique case (state_reg)
            IDLE:
            begin
                if (in_valid)
                begin
                    stream_next = stream_id;
                    seq_next = seq_num;
                    tag_next = frame_tag;
                    if (!exp_known_reg[stream_id])
                    begin
                        exp_seq_next[stream_id] = seq_num;
                        exp_known_next[stream_id] = 1'b1;
                    end
                    gap_next = 1'b0;
                    pend_next = 1'b0;
                    idx_next = '0;
                    state_next = CHECK;
                end
            end
            CHECK, SCAN:
            begin
                if (idx_reg == '0)
                begin
                    match_next = 1'b0;
                    min_ok_next = 1'b0;
                end
                if (idx_reg < (srb_pkg::SLOT_W+1)'(srb_pkg::SLOTS))
                begin
                    rd_valid_next = 1'b1;
                    rd_slot_next = idx_reg[srb_pkg::SLOT_W-1:0];
                    idx_next = idx_reg + 1'b1;
                end
                if (rd_valid_reg && used_s[rd_slot_reg])
                begin
                    if (ram_rdata.seq == scan_key)
                    begin
                        match_next = 1'b1;
                        match_slot_next = rd_slot_reg;
                        match_tag_next = ram_rdata.tag;
                    end
                    if (!min_ok_reg || ram_rdata.seq < min_seq_reg)
                    begin
                        min_ok_next = 1'b1;
                        min_seq_next = ram_rdata.seq;
                        min_slot_next = rd_slot_reg;
                    end
                end
                if (rd_valid_reg && rd_slot_reg == srb_pkg::SLOT_W'(srb_pkg::SLOTS - 1))
                    state_next = (state_reg == CHECK) ? INSERT : DECIDE;
            end
            INSERT:
            begin
                idx_next = '0;
                if (store_ok)
                begin
                    used_next[{stream_reg, free_idx}] = 1'b1;
                    state_next = SCAN;
                end
                else
                    state_next = IDLE;
            end
            DECIDE:
            begin
                idx_next = '0;
                priority if (match_reg)
                begin
                    // staged result goes out once the next one is known to exist
                    if (!pend_reg || out_free)
                    begin
                        if (pend_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_stream_next = stream_reg;
                            out_seq_next = pend_seq_reg;
                            out_tag_next = pend_tag_reg;
                            out_gap_next = pend_gap_reg;
                            out_last_next = 1'b0;
                        end
                        pend_next = 1'b1;
                        pend_seq_next = exp_cur;
                        pend_tag_next = match_tag_reg;
                        pend_gap_next = gap_reg;
                        gap_next = 1'b0;
                        used_next[{stream_reg, match_slot_reg}] = 1'b0;
                        exp_seq_next[stream_reg] = exp_cur + 1'b1;
                        state_next = SCAN;
                    end
                end
                else if (held < limit)
                begin
                    if (!pend_reg)
                        state_next = IDLE;
                    else if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_stream_next = stream_reg;
                        out_seq_next = pend_seq_reg;
                        out_tag_next = pend_tag_reg;
                        out_gap_next = pend_gap_reg;
                        out_last_next = 1'b1;
                        pend_next = 1'b0;
                        state_next = IDLE;
                    end
                end
                else if (min_seq_reg > exp_cur)
                begin
                    exp_seq_next[stream_reg] = min_seq_reg;
                    gap_next = 1'b1;
                    state_next = SCAN;
                end
                else
                begin
                    used_next[{stream_reg, min_slot_reg}] = 1'b0;
                    state_next = SCAN;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            idx_reg <= '0;
            rd_valid_reg <= 1'b0;
            exp_seq_reg <= '0;
            exp_known_reg <= '0;
            used_reg <= '0;
            pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            rd_valid_reg <= rd_valid_next;
            exp_seq_reg <= exp_seq_next;
            exp_known_reg <= exp_known_next;
            used_reg <= used_next;
            pend_reg <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_slot_reg <= rd_slot_next;
        stream_reg <= stream_next;
        seq_reg <= seq_next;
        tag_reg <= tag_next;
        match_reg <= match_next;
        match_slot_reg <= match_slot_next;
        match_tag_reg <= match_tag_next;
        min_ok_reg <= min_ok_next;
        min_seq_reg <= min_seq_next;
        min_slot_reg <= min_slot_next;
        gap_reg <= gap_next;
        pend_seq_reg <= pend_seq_next;
        pend_tag_reg <= pend_tag_next;
        pend_gap_reg <= pend_gap_next;
        out_stream_reg <= out_stream_next;
        out_seq_reg <= out_seq_next;
        out_tag_reg <= out_tag_next;
        out_gap_reg <= out_gap_next;
        out_last_reg <= out_last_next;
    end

endmodule
